// File: rtl/sla_pkg.sv
// Shared types, mode codes, colors and constants for the status LED animator.
// No dependencies; used by sla_core and status_led_animator_unit.
`timescale 1ns / 1ps

package sla_pkg;

  // Mode codes, same encoding as the new_mode and mode_now fields.
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_LISTENING  = 3'd1,
    MODE_PROCESSING = 3'd2,
    MODE_RECORDING  = 3'd3,
    MODE_UPLOADING  = 3'd4,
    MODE_SUCCESS    = 3'd5,
    MODE_ERROR      = 3'd6,
    MODE_QUEUED     = 3'd7
  } mode_t;

  // Input kinds.
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_CHANGE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_PULSE_INTERVAL = 2'd0;
  localparam logic [1:0] REG_SUCCESS_DUR    = 2'd1;
  localparam logic [1:0] REG_ERROR_DUR      = 2'd2;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  PULSE_INTERVAL_RST = 8'd20;
  localparam logic [11:0] SUCCESS_DUR_RST    = 12'd1500;
  localparam logic [11:0] ERROR_DUR_RST      = 12'd2500;

  // Animation constants.
  localparam logic [11:0] ELAPSED_MAX = 12'd4095;
  localparam logic [7:0]  LEVEL_STEP  = 8'd5;
  localparam logic [7:0]  LEVEL_TOP   = 8'd250;

  // elapsed / 250 is computed as (elapsed * 4195) >> 20, exact for elapsed below 4096.
  localparam logic [12:0] FLASH_RECIP = 13'd4195;
  localparam int          FLASH_SHIFT = 20;

  // Colors as 0xRRGGBB.
  localparam logic [23:0] COLOR_BLACK  = 24'h000000;
  localparam logic [23:0] COLOR_GREEN  = 24'h008000;
  localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
  localparam logic [23:0] COLOR_RED    = 24'hFF0000;
  localparam logic [23:0] COLOR_CYAN   = 24'h00FFFF;
  localparam logic [23:0] COLOR_ORANGE = 24'hFFA500;
  localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;

  // One result word.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       led_written;
    logic [2:0] mode_now;
  } result_t;

  // Base color of a breathing mode.
  function automatic logic [23:0] breath_color(input mode_t m);
    logic [23:0] c;
    case (m)
      MODE_IDLE:      c = COLOR_GREEN;
      MODE_LISTENING: c = COLOR_BLUE;
      MODE_RECORDING: c = COLOR_RED;
      MODE_UPLOADING: c = COLOR_CYAN;
      default:        c = COLOR_ORANGE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/sla_core.sv
// Mode state, configuration registers and the per-word animation update.
// Depends on sla_pkg for mode codes, colors and the result word type.
`timescale 1ns / 1ps

module sla_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          fire,
  input  logic                          kind,
  input  logic [2:0]                    new_mode,
  output sla_pkg::result_t              res
);

  // Configuration registers.
  logic [7:0]  pulse_interval_ms;
  logic [11:0] success_duration_ms;
  logic [11:0] error_duration_ms;

  // Animation state.
  sla_pkg::mode_t mode, mode_next;
  logic [11:0]    elapsed_ms, elapsed_ms_next;
  logic [7:0]     level, level_next;
  logic           rising, rising_next;
  logic [23:0]    shown_color, shown_color_next;
  logic           written;

  // Helpers for the tick path.
  logic [11:0] elapsed_inc;
  logic [7:0]  level_step;
  logic        rising_step;
  logic [23:0] base;
  logic [15:0] prod_r, prod_g, prod_b;
  logic [23:0] breath_shown;
  logic [24:0] flash_prod;
  logic [11:0] flash_dur;
  logic [23:0] flash_on;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_interval_ms   <= sla_pkg::PULSE_INTERVAL_RST;
      success_duration_ms <= sla_pkg::SUCCESS_DUR_RST;
      error_duration_ms   <= sla_pkg::ERROR_DUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sla_pkg::REG_PULSE_INTERVAL: pulse_interval_ms <= cfg_data[7:0];
        sla_pkg::REG_SUCCESS_DUR:    success_duration_ms <= cfg_data;
        sla_pkg::REG_ERROR_DUR:      error_duration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating millisecond count.
  assign elapsed_inc = (elapsed_ms == sla_pkg::ELAPSED_MAX) ? elapsed_ms
                                                            : elapsed_ms + 12'd1;

  // One brightness step and its direction.
  always_comb begin
    if (rising) begin
      level_step  = level + sla_pkg::LEVEL_STEP;
      rising_step = !(level_step >= sla_pkg::LEVEL_TOP);
    end else begin
      level_step  = level - sla_pkg::LEVEL_STEP;
      rising_step = (level_step <= sla_pkg::LEVEL_STEP);
    end
  end

  // Scale each channel of the base color by the new level.
  assign base   = sla_pkg::breath_color(mode);
  assign prod_r = {8'd0, base[23:16]} * {8'd0, level_step};
  assign prod_g = {8'd0, base[15:8]}  * {8'd0, level_step};
  assign prod_b = {8'd0, base[7:0]}   * {8'd0, level_step};
  assign breath_shown = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};

  // Flash phase: odd quarter-second periods show the color.
  assign flash_prod = {13'd0, elapsed_inc} * {12'd0, sla_pkg::FLASH_RECIP};
  assign flash_dur  = (mode == sla_pkg::MODE_SUCCESS) ? success_duration_ms
                                                      : error_duration_ms;
  assign flash_on   = (mode == sla_pkg::MODE_SUCCESS) ? sla_pkg::COLOR_GREEN
                                                      : sla_pkg::COLOR_RED;

  // Next state for one accepted word.
  always_comb begin
    mode_next        = mode;
    elapsed_ms_next  = elapsed_ms;
    level_next       = level;
    rising_next      = rising;
    shown_color_next = shown_color;
    written          = 1'b0;
    if (kind == sla_pkg::KIND_CHANGE) begin
      if (sla_pkg::mode_t'(new_mode) != mode) begin
        mode_next       = sla_pkg::mode_t'(new_mode);
        level_next      = 8'd0;
        rising_next     = 1'b1;
        elapsed_ms_next = 12'd0;
      end
    end else begin
      elapsed_ms_next = elapsed_inc;
      case (mode)
        sla_pkg::MODE_PROCESSING: begin
          shown_color_next = sla_pkg::COLOR_YELLOW;
          written          = 1'b1;
        end
        sla_pkg::MODE_SUCCESS, sla_pkg::MODE_ERROR: begin
          if (elapsed_inc < flash_dur) begin
            shown_color_next = flash_prod[sla_pkg::FLASH_SHIFT] ? flash_on
                                                                : sla_pkg::COLOR_BLACK;
            written          = 1'b1;
          end else begin
            // Flashing is over: fall back to idle as with a mode change.
            mode_next       = sla_pkg::MODE_IDLE;
            level_next      = 8'd0;
            rising_next     = 1'b1;
            elapsed_ms_next = 12'd0;
          end
        end
        default: begin
          if (elapsed_inc > {4'd0, pulse_interval_ms}) begin
            elapsed_ms_next  = 12'd0;
            level_next       = level_step;
            rising_next      = rising_step;
            shown_color_next = breath_shown;
            written          = 1'b1;
          end
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sla_pkg::MODE_IDLE;
      elapsed_ms  <= 12'd0;
      level       <= 8'd0;
      rising      <= 1'b1;
      shown_color <= sla_pkg::COLOR_BLACK;
    end else if (fire) begin
      mode        <= mode_next;
      elapsed_ms  <= elapsed_ms_next;
      level       <= level_next;
      rising      <= rising_next;
      shown_color <= shown_color_next;
    end
  end

  // Result word for the word being accepted.
  assign res.red         = shown_color_next[23:16];
  assign res.green       = shown_color_next[15:8];
  assign res.blue        = shown_color_next[7:0];
  assign res.led_written = written;
  assign res.mode_now    = mode_next;

endmodule

// File: rtl/status_led_animator_unit.sv
// Top level of the status LED animator: core update plus a two-word result queue.
// Depends on sla_pkg and sla_core.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid, in_stall, kind, new_mode) carries one word per
//   millisecond tick (kind 0) or mode change request (kind 1). The output channel
//   (out_valid, out_stall, red, green, blue, led_written, mode_now) returns exactly
//   one word per input word, in order.
//   Each accepted word updates the mode state in the cycle it is accepted; its
//   result is registered into the queue and appears once earlier results leave.
//   Throughput is one word per cycle while the receiver does not stall, set by
//   the state update and the two-entry result queue.
//   While the receiver stalls, up to two results wait in the queue; in_stall is
//   high exactly while both entries are occupied, so it drops in the cycle after
//   a result is taken.
//   Configuration is written through cfg_we, cfg_index and cfg_data while idle.
//   Synchronous reset restores idle mode, black color, level zero, rising direction,
//   the default register values, and empties the queue.

module status_led_animator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [2:0]                     new_mode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue,
  output logic                           led_written,
  output logic [2:0]                     mode_now
);

  sla_pkg::result_t res;
  sla_pkg::result_t slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push, pop;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  sla_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (push),
    .kind      (kind),
    .new_mode  (new_mode),
    .res       (res)
  );

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= res;
  end

  // Channel outputs.
  assign in_stall    = (count == 2'd2);
  assign out_valid   = (count != 2'd0);
  assign red         = slot[rd_ptr].red;
  assign green       = slot[rd_ptr].green;
  assign blue        = slot[rd_ptr].blue;
  assign led_written = slot[rd_ptr].led_written;
  assign mode_now    = slot[rd_ptr].mode_now;

endmodule
